>>> design/ggpw_pkg.sv
// ----------------------------------------------------------------------------
// ggpw_pkg: shared types and constants of the greedy grid path walker
// Transaction payloads, register indexes, outcome codes, neighbor offsets
// and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ggpw_pkg;

  typedef struct packed {
    logic       op;
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic       cell_blocked;
    logic [4:0] goal_row;
    logic [4:0] goal_col;
  } ggpw_in_t;

  typedef struct packed {
    logic [4:0] step_row;
    logic [4:0] step_col;
    logic       step_valid;
    logic       last_step;
    logic [1:0] outcome;
  } ggpw_out_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_WALK  = 1'b1;

  localparam logic REG_ACTIVE_ROWS = 1'b0;
  localparam logic REG_ACTIVE_COLS = 1'b1;

  localparam logic [5:0] ACTIVE_RESET = 6'd25;

  localparam logic [1:0] OUTC_GOAL  = 2'd0;
  localparam logic [1:0] OUTC_STUCK = 2'd1;
  localparam logic [1:0] OUTC_LIMIT = 2'd2;

  localparam int NB_COUNT = 8;

  // above, upper left, upper right, left, right, below, lower left, lower right
  localparam logic signed [1:0] NB_DR [NB_COUNT] = '{
    -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1
  };
  localparam logic signed [1:0] NB_DC [NB_COUNT] = '{
    2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, 2'sd0, -2'sd1, 2'sd1
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_MOD,
    ST_CHECK,
    ST_RD_MID,
    ST_RD_DN,
    ST_EVAL,
    ST_PICK
  } ggpw_state_t;

endpackage

`default_nettype wire

>>> design/greedy_grid_path_walker.sv
// ----------------------------------------------------------------------------
// greedy_grid_path_walker: obstacle map and greedy 8-connected walker
// Busy: a cell write holds busy through its write-back state. A walk holds busy
// per move through three serial map row reads, one evaluation and one pick, then
// through a final goal/limit check, or it ends at the pick when it ends stuck.
// Throughput: one transaction at a time; each result is registered in the cycle
// after its move is known final or not; the receiver cannot stall.
// Reset: synchronous; the map reads as all open (per-row valid flags), sizes 25.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_grid_path_walker #(
  parameter int GRID_DIM  = 32,
  parameter int MAX_STEPS = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  ggpw_pkg::ggpw_in_t  in_data,
  output logic                out_valid,
  output ggpw_pkg::ggpw_out_t out_data,
  input  wire                 cfg_we,
  input  wire                 cfg_idx,
  input  wire  [5:0]          cfg_data
);

  import ggpw_pkg::*;

  localparam int EFF_DIM = (GRID_DIM < 32) ? GRID_DIM : 32;
  localparam int AW      = $clog2(EFF_DIM);
  localparam int CW      = $clog2(MAX_STEPS + 1);
  localparam logic [5:0] EFF_W = 6'(EFF_DIM);

  // map memory, one word per row
  logic [EFF_DIM-1:0] mem [EFF_DIM];
  logic [EFF_DIM-1:0] rd_data_r;
  logic               rd_vld_r;
  logic [EFF_DIM-1:0] row_valid_r;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [EFF_DIM-1:0] mem_wd;
  logic [EFF_DIM-1:0] rd_word;

  ggpw_state_t state_r, state_nxt;

  logic [5:0]    rows_r, cols_r;
  logic [5:0]    lim_r6, lim_c6;
  logic [4:0]    cur_r_r, cur_c_r, cur_r_nxt, cur_c_nxt;
  logic [4:0]    prev_r_r, prev_c_r, prev_r_nxt, prev_c_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [4:0]    goal_r_r, goal_c_r, goal_r_nxt, goal_c_nxt;
  logic [4:0]    wr_row_r, wr_col_r;
  logic          wr_blk_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [4:0]    pend_row_r, pend_col_r, pend_row_nxt, pend_col_nxt;
  logic [EFF_DIM-1:0] row_up_r, row_up_nxt, row_mid_r, row_mid_nxt;

  logic          nb_ok_r   [NB_COUNT];
  logic [10:0]   nb_dist_r [NB_COUNT];
  logic [4:0]    nb_row_r  [NB_COUNT];
  logic [4:0]    nb_col_r  [NB_COUNT];
  logic          nb_ok     [NB_COUNT];
  logic [10:0]   nb_dist   [NB_COUNT];
  logic [4:0]    nb_row    [NB_COUNT];
  logic [4:0]    nb_col    [NB_COUNT];

  logic          out_valid_r, out_valid_nxt;
  ggpw_out_t     out_data_r, out_data_nxt;

  logic          best_found;
  logic [10:0]   best_d;
  logic [4:0]    best_row, best_col;

  logic [6:0]    rd_row7;
  logic          accept;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign lim_r6  = (rows_r > EFF_W) ? EFF_W : rows_r;
  assign lim_c6  = (cols_r > EFF_W) ? EFF_W : cols_r;
  assign rd_word = rd_vld_r ? rd_data_r : '0;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // read address: row above, own row or row below; out-of-grid rows map to 0
  always_comb begin
    case (state_r)
      ST_CHECK:  rd_row7 = {2'b00, cur_r_r} - 7'd1;
      ST_RD_MID: rd_row7 = {2'b00, cur_r_r};
      ST_RD_DN:  rd_row7 = {2'b00, cur_r_r} + 7'd1;
      default:   rd_row7 = {2'b00, in_data.cell_row};
    endcase
    if (!rd_row7[6] && (rd_row7[5:0] < EFF_W)) begin
      rd_addr = rd_row7[AW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  // cell write is a read-modify-write of one row
  always_comb begin
    mem_we = (state_r == ST_WR_MOD);
    mem_wd = rd_word;
    if (wr_blk_r) begin
      mem_wd = rd_word | (EFF_DIM'(1) << wr_col_r);
    end else begin
      mem_wd = rd_word & ~(EFF_DIM'(1) << wr_col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_row_r[AW-1:0]] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= row_valid_r[rd_addr];
      if (mem_we) begin
        row_valid_r[wr_row_r[AW-1:0]] <= 1'b1;
      end
    end
  end

  // neighbor evaluation, eight independent lanes
  always_comb begin
    logic signed [6:0] nr, nc, dgr, dgc;
    logic [6:0]        adr, adc;
    logic [EFF_DIM-1:0] word, shifted;
    logic              in_r, in_c, blk, is_prev;
    for (int k = 0; k < NB_COUNT; k++) begin
      nr = $signed({2'b00, cur_r_r}) + 7'(NB_DR[k]);
      nc = $signed({2'b00, cur_c_r}) + 7'(NB_DC[k]);
      in_r = !nr[6] && (nr[5:0] < lim_r6);
      in_c = !nc[6] && (nc[5:0] < lim_c6);
      if (NB_DR[k] == -2'sd1) begin
        word = row_up_r;
      end else if (NB_DR[k] == 2'sd0) begin
        word = row_mid_r;
      end else begin
        word = rd_word;
      end
      shifted = word >> nc[5:0];
      blk = shifted[0];
      is_prev = have_prev_r && (nr[4:0] == prev_r_r) && (nc[4:0] == prev_c_r);
      nb_ok[k] = in_r && in_c && !blk && !is_prev;
      dgr = $signed({2'b00, goal_r_r}) - nr;
      dgc = $signed({2'b00, goal_c_r}) - nc;
      adr = dgr[6] ? 7'(-dgr) : 7'(dgr);
      adc = dgc[6] ? 7'(-dgc) : 7'(dgc);
      nb_dist[k] = 11'(adr[4:0]) * 11'(adr[4:0]) + 11'(adc[4:0]) * 11'(adc[4:0]);
      nb_row[k] = nr[4:0];
      nb_col[k] = nc[4:0];
    end
  end

  // first strictly smallest distance wins
  always_comb begin
    best_found = 1'b0;
    best_d     = '0;
    best_row   = '0;
    best_col   = '0;
    for (int k = 0; k < NB_COUNT; k++) begin
      if (nb_ok_r[k] && (!best_found || (nb_dist_r[k] < best_d))) begin
        best_found = 1'b1;
        best_d     = nb_dist_r[k];
        best_row   = nb_row_r[k];
        best_col   = nb_col_r[k];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_r_nxt     = cur_r_r;
    cur_c_nxt     = cur_c_r;
    prev_r_nxt    = prev_r_r;
    prev_c_nxt    = prev_c_r;
    have_prev_nxt = have_prev_r;
    goal_r_nxt    = goal_r_r;
    goal_c_nxt    = goal_c_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_row_nxt  = pend_row_r;
    pend_col_nxt  = pend_col_r;
    row_up_nxt    = row_up_r;
    row_mid_nxt   = row_mid_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_WALK) begin
            cur_r_nxt     = in_data.cell_row;
            cur_c_nxt     = in_data.cell_col;
            goal_r_nxt    = in_data.goal_row;
            goal_c_nxt    = in_data.goal_col;
            have_prev_nxt = 1'b0;
            cnt_nxt       = '0;
            pend_nxt      = 1'b0;
            state_nxt     = ST_CHECK;
          end else if ((6'(in_data.cell_row) < EFF_W) &&
                       (6'(in_data.cell_col) < EFF_W)) begin
            state_nxt = ST_WR_MOD;
          end
        end
      end
      ST_WR_MOD: begin
        state_nxt = ST_IDLE;
      end
      ST_CHECK: begin
        if ((cur_r_r == goal_r_r && cur_c_r == goal_c_r) ||
            (cnt_r >= CW'(MAX_STEPS))) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.step_row   = pend_r ? pend_row_r : 5'd0;
          out_data_nxt.step_col   = pend_r ? pend_col_r : 5'd0;
          out_data_nxt.step_valid = pend_r;
          out_data_nxt.last_step  = 1'b1;
          out_data_nxt.outcome    = (cur_r_r == goal_r_r && cur_c_r == goal_c_r)
                                    ? OUTC_GOAL : OUTC_LIMIT;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_RD_MID;
        end
      end
      ST_RD_MID: begin
        row_up_nxt = rd_word;
        state_nxt  = ST_RD_DN;
      end
      ST_RD_DN: begin
        row_mid_nxt = rd_word;
        state_nxt   = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (!best_found) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.step_row   = pend_r ? pend_row_r : 5'd0;
          out_data_nxt.step_col   = pend_r ? pend_col_r : 5'd0;
          out_data_nxt.step_valid = pend_r;
          out_data_nxt.last_step  = 1'b1;
          out_data_nxt.outcome    = OUTC_STUCK;
          state_nxt = ST_IDLE;
        end else begin
          // the previous move is known not to be the last one now
          if (pend_r) begin
            out_valid_nxt           = 1'b1;
            out_data_nxt.step_row   = pend_row_r;
            out_data_nxt.step_col   = pend_col_r;
            out_data_nxt.step_valid = 1'b1;
            out_data_nxt.last_step  = 1'b0;
            out_data_nxt.outcome    = OUTC_GOAL;
          end
          pend_nxt      = 1'b1;
          pend_row_nxt  = best_row;
          pend_col_nxt  = best_col;
          prev_r_nxt    = cur_r_r;
          prev_c_nxt    = cur_c_r;
          have_prev_nxt = 1'b1;
          cur_r_nxt     = best_row;
          cur_c_nxt     = best_col;
          cnt_nxt       = cnt_r + CW'(1);
          state_nxt     = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= ACTIVE_RESET;
      cols_r      <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
      have_prev_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      have_prev_r <= have_prev_nxt;
      pend_r      <= pend_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        if (cfg_idx == REG_ACTIVE_ROWS) begin
          rows_r <= cfg_data;
        end else begin
          rows_r <= rows_r;
        end
        if (cfg_idx == REG_ACTIVE_COLS) begin
          cols_r <= cfg_data;
        end else begin
          cols_r <= cols_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r_r    <= cur_r_nxt;
    cur_c_r    <= cur_c_nxt;
    prev_r_r   <= prev_r_nxt;
    prev_c_r   <= prev_c_nxt;
    goal_r_r   <= goal_r_nxt;
    goal_c_r   <= goal_c_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    row_up_r   <= row_up_nxt;
    row_mid_r  <= row_mid_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      wr_row_r <= in_data.cell_row;
      wr_col_r <= in_data.cell_col;
      wr_blk_r <= in_data.cell_blocked;
    end
    for (int k = 0; k < NB_COUNT; k++) begin
      nb_ok_r[k]   <= nb_ok[k];
      nb_dist_r[k] <= nb_dist[k];
      nb_row_r[k]  <= nb_row[k];
      nb_col_r[k]  <= nb_col[k];
    end
  end

endmodule

`default_nettype wire
